// File: src/dwd_pkg.sv
// Package for the drivetrain wheel derivatives unit: register codes, reset
// values, fixed widths and the structs shared between the front, the queue
// and the back. No dependencies.
`default_nettype none

package dwd_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_VEHICLE_MASS        = 3'd0,
        CFG_ACCEL_BIAS_FRONT    = 3'd1,
        CFG_BRAKE_BIAS_FRONT    = 3'd2,
        CFG_TIRE_RADIUS_FRONT   = 3'd3,
        CFG_TIRE_RADIUS_REAR    = 3'd4,
        CFG_INERTIA_FRONT       = 3'd5,
        CFG_INERTIA_REAR        = 3'd6,
        CFG_ACCEL_TIME_CONSTANT = 3'd7
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [31:0] RstVehicleMass      = 32'd52428800;
    localparam logic [16:0] RstAccelBiasFront   = 17'd32768;
    localparam logic [16:0] RstBrakeBiasFront   = 17'd39322;
    localparam logic [17:0] RstTireRadiusFront  = 18'd19661;
    localparam logic [17:0] RstTireRadiusRear   = 18'd19661;
    localparam logic [24:0] RstInertiaFront     = 25'd78643;
    localparam logic [24:0] RstInertiaRear      = 25'd78643;
    localparam logic [24:0] RstAccelTimeConst   = 25'd6554;

    // A bias of one in Q1.16, and the low-speed knee of 20 rad/s in Q15.16.
    localparam logic [16:0] BiasOne       = 17'd65536;
    localparam logic [33:0] LowSpeedKnee  = 34'd1310720;

    // Divider operand widths, the number of quotient bits and the number of front stages.
    localparam int WheelMagW  = 53;
    localparam int WheelDenW  = 43;
    localparam int AccelMagW  = 49;
    localparam int AccelDenW  = 25;
    localparam int DivStages  = 32;
    localparam int FrontStages = 6;

    typedef struct packed {
        logic [31:0] vehicle_mass;
        logic [16:0] accel_bias_front;
        logic [16:0] brake_bias_front;
        logic [17:0] tire_radius_front;
        logic [17:0] tire_radius_rear;
        logic [24:0] inertia_front;
        logic [24:0] inertia_rear;
        logic [24:0] accel_time_constant;
    } t_cfg;

    // One classified item: magnitudes, divisors, sign and stop flags for the
    // five divisions. Index 0 is front left, 1 front right, 2 rear left,
    // 3 rear right.
    typedef struct packed {
        logic [3:0][WheelMagW-1:0] mag_w;
        logic [3:0][WheelDenW-1:0] den_w;
        logic [3:0]                neg_w;
        logic [3:0]                stop_w;
        logic [AccelMagW-1:0]      mag_a;
        logic [AccelDenW-1:0]      den_a;
        logic                      neg_a;
    } t_job;

endpackage

`default_nettype wire

// File: src/drivetrain_wheel_derivatives_unit.sv
// Top level of the drivetrain wheel derivatives unit: configuration
// registers, front, queue and back. Depends on dwd_pkg, dwd_front,
// dwd_queue and dwd_back.
//
//   Channel   Signals                              Handshake
//   input     start, busy, i_<fields>              taken when start & !busy
//   config    i_cfg_we, i_cfg_idx, i_cfg_data      written when i_cfg_we
//   result    o_valid, o_<fields>                  one-cycle strobe
//
// One item per cycle is accepted while busy is low; each result passes
// through six front stages, the queue register and the divider registers,
// which resolve one quotient bit per stage.
// Reset is synchronous and active low; it restores the register defaults
// and empties the pipeline. The receiver cannot stall, so the queue drains
// every cycle and busy stays low.
`default_nettype none

module drivetrain_wheel_derivatives_unit #(
    parameter int QueueDepth = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire  [31:0] i_accel_state,
    input  wire  [31:0] i_speed_front_left,
    input  wire  [31:0] i_speed_front_right,
    input  wire  [31:0] i_speed_rear_left,
    input  wire  [31:0] i_speed_rear_right,
    input  wire  [47:0] i_external_force,
    input  wire  [31:0] i_tire_torque_front_left,
    input  wire  [31:0] i_tire_torque_front_right,
    input  wire  [31:0] i_tire_torque_rear_left,
    input  wire  [31:0] i_tire_torque_rear_right,
    input  wire  [31:0] i_accel_target,
    output logic        o_valid,
    output logic [31:0] o_wheel_accel_front_left,
    output logic [31:0] o_wheel_accel_front_right,
    output logic [31:0] o_wheel_accel_rear_left,
    output logic [31:0] o_wheel_accel_rear_right,
    output logic [31:0] o_accel_rate
);
    import dwd_pkg::*;

    localparam int Latency = FrontStages + 1 + DivStages + 2;

    t_cfg             r_cfg;
    logic             take;
    logic             front_v, queue_v;
    t_job             front_job, queue_job;
    logic [3:0][31:0] wheel;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vehicle_mass        <= RstVehicleMass;
            r_cfg.accel_bias_front    <= RstAccelBiasFront;
            r_cfg.brake_bias_front    <= RstBrakeBiasFront;
            r_cfg.tire_radius_front   <= RstTireRadiusFront;
            r_cfg.tire_radius_rear    <= RstTireRadiusRear;
            r_cfg.inertia_front       <= RstInertiaFront;
            r_cfg.inertia_rear        <= RstInertiaRear;
            r_cfg.accel_time_constant <= RstAccelTimeConst;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_VEHICLE_MASS:        r_cfg.vehicle_mass        <= i_cfg_data;
                CFG_ACCEL_BIAS_FRONT:    r_cfg.accel_bias_front    <= i_cfg_data[16:0];
                CFG_BRAKE_BIAS_FRONT:    r_cfg.brake_bias_front    <= i_cfg_data[16:0];
                CFG_TIRE_RADIUS_FRONT:   r_cfg.tire_radius_front   <= i_cfg_data[17:0];
                CFG_TIRE_RADIUS_REAR:    r_cfg.tire_radius_rear    <= i_cfg_data[17:0];
                CFG_INERTIA_FRONT:       r_cfg.inertia_front       <= i_cfg_data[24:0];
                CFG_INERTIA_REAR:        r_cfg.inertia_rear        <= i_cfg_data[24:0];
                CFG_ACCEL_TIME_CONSTANT: r_cfg.accel_time_constant <= i_cfg_data[24:0];
                default:                 r_cfg <= r_cfg;
            endcase
        end
    end

    // An item enters when started and the queue has room.
    assign take = start & ~busy;

    dwd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_cfg            (r_cfg),
        .i_accel_state    (i_accel_state),
        .i_speed          ({i_speed_rear_right, i_speed_rear_left,
                            i_speed_front_right, i_speed_front_left}),
        .i_external_force (i_external_force),
        .i_tire_torque    ({i_tire_torque_rear_right, i_tire_torque_rear_left,
                            i_tire_torque_front_right, i_tire_torque_front_left}),
        .i_accel_target   (i_accel_target),
        .o_valid          (front_v),
        .o_job            (front_job)
    );

    dwd_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_v),
        .i_job   (front_job),
        .o_valid (queue_v),
        .o_job   (queue_job),
        .o_full  (busy)
    );

    dwd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_v),
        .i_job   (queue_job),
        .o_valid (o_valid),
        .o_wheel (wheel),
        .o_rate  (o_accel_rate)
    );

    assign o_wheel_accel_front_left  = wheel[0];
    assign o_wheel_accel_front_right = wheel[1];
    assign o_wheel_accel_rear_left   = wheel[2];
    assign o_wheel_accel_rear_right  = wheel[3];

    // The back drains one item per cycle, so the queue never fills.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue filled up");

    // Every accepted item comes out after the fixed pipeline latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##Latency o_valid)
        else $error("result missing after pipeline latency");

endmodule

`default_nettype wire

// File: src/dwd_front.sv
// Front part of the drivetrain wheel derivatives unit: force, axle split, drive torques,
// wheel inertias, net torques and the acceleration error in six register stages.
// Depends on dwd_pkg.
`default_nettype none

module dwd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  dwd_pkg::t_cfg       i_cfg,
    input  wire  [31:0]         i_accel_state,
    input  wire  [3:0][31:0]    i_speed,
    input  wire  [47:0]         i_external_force,
    input  wire  [3:0][31:0]    i_tire_torque,
    input  wire  [31:0]         i_accel_target,
    output logic                o_valid,
    output dwd_pkg::t_job       o_job
);
    import dwd_pkg::*;

    // Raw input fields carried alongside the arithmetic.
    typedef struct packed {
        logic [3:0][31:0] tt;
        logic [31:0]      tgt;
        logic [31:0]      acc;
        logic [3:0]       stop;
    } t_carry;

    logic [FrontStages-1:0] r_v;

    // Stage 1 registers.
    t_carry             r1_c, n1_c;
    logic signed [64:0] r1_prod;
    logic [47:0]        r1_ext;
    logic signed [33:0] r1_d [4];
    logic signed [33:0] n1_d [4];

    // Stage 2 registers.
    t_carry             r2_c;
    logic signed [48:0] r2_force, n2_force;
    logic [41:0]        r2_low [4];
    logic [41:0]        n2_low [4];
    logic [26:0]        ir3;
    logic [59:0]        lp [4];

    // Stage 3 registers.
    t_carry             r3_c;
    logic signed [48:0] r3_force;
    logic [34:0]        r3_kf, r3_kr, n3_kf, n3_kr;
    logic [WheelDenW-1:0] r3_inr [4];
    logic [WheelDenW-1:0] n3_inr [4];
    logic [16:0]        bias, bias_rear;

    // Stage 4 registers.
    t_carry             r4_c;
    logic signed [67:0] r4_pfl, r4_prl, n4_pfl, n4_prl;
    logic signed [66:0] r4_pfh, r4_prh, n4_pfh, n4_prh;
    logic [WheelDenW-1:0] r4_inr [4];

    // Stage 5 registers.
    t_carry             r5_c;
    logic signed [52:0] r5_drf, r5_drr, n5_drf, n5_drr;
    logic signed [85:0] sum_f, sum_r;
    logic [WheelDenW-1:0] r5_inr [4];

    // Stage 6 output register.
    t_job               r6_job, n6_job;
    logic signed [53:0] numw [4];
    logic [53:0]        magw [4];
    logic signed [32:0] diff_a;
    logic [32:0]        abs_a;

    // Valid bits through the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FrontStages-2:0], i_take};
        end
    end

    // Stage 1: mass product, distance below the low-speed knee.
    always_comb begin
        n1_c.tt  = i_tire_torque;
        n1_c.tgt = i_accel_target;
        n1_c.acc = i_accel_state;
        for (int i = 0; i < 4; i++) begin
            n1_d[i]      = $signed(LowSpeedKnee) - $signed({{2{i_speed[i][31]}}, i_speed[i]});
            n1_c.stop[i] = i_speed[i][31] || (i_speed[i] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_c    <= n1_c;
        r1_prod <= $signed(i_accel_state) * $signed({1'b0, i_cfg.vehicle_mass});
        r1_ext  <= i_external_force;
        for (int i = 0; i < 4; i++) begin
            r1_d[i] <= n1_d[i];
        end
    end

    // Stage 2: target force and the low-speed inertia term.
    always_comb begin
        ir3 = {1'b0, i_cfg.inertia_rear, 1'b0} + {2'b00, i_cfg.inertia_rear};
        n2_force = $signed(r1_prod[64:16]) - $signed({r1_ext[47], r1_ext});
        for (int i = 0; i < 4; i++) begin
            lp[i] = 60'(ir3) * 60'(r1_d[i][32:0]);
            if (!r1_d[i][33] && (r1_d[i] != '0)) begin
                n2_low[i] = lp[i][59:18];
            end else begin
                n2_low[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r2_c     <= r1_c;
        r2_force <= n2_force;
        for (int i = 0; i < 4; i++) begin
            r2_low[i] <= n2_low[i];
        end
    end

    // Stage 3: axle share times tire radius, total wheel inertia.
    always_comb begin
        if (!r2_force[48] && (r2_force != '0)) begin
            bias = i_cfg.accel_bias_front;
        end else begin
            bias = i_cfg.brake_bias_front;
        end
        if (bias > BiasOne) begin
            bias = BiasOne;
        end
        bias_rear = BiasOne - bias;
        n3_kf = 35'(bias) * 35'(i_cfg.tire_radius_front);
        n3_kr = 35'(bias_rear) * 35'(i_cfg.tire_radius_rear);
        for (int i = 0; i < 4; i++) begin
            n3_inr[i] = WheelDenW'(i < 2 ? i_cfg.inertia_front : i_cfg.inertia_rear)
                      + WheelDenW'(r2_low[i]);
            if (n3_inr[i] == '0) begin
                n3_inr[i] = WheelDenW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_c     <= r2_c;
        r3_force <= r2_force;
        r3_kf    <= n3_kf;
        r3_kr    <= n3_kr;
        for (int i = 0; i < 4; i++) begin
            r3_inr[i] <= n3_inr[i];
        end
    end

    // Stage 4: force times share, split into low and high partial products.
    always_comb begin
        n4_pfl = r3_force * $signed({1'b0, r3_kf[17:0]});
        n4_pfh = r3_force * $signed({1'b0, r3_kf[34:18]});
        n4_prl = r3_force * $signed({1'b0, r3_kr[17:0]});
        n4_prh = r3_force * $signed({1'b0, r3_kr[34:18]});
    end

    always_ff @(posedge i_clk) begin
        r4_c   <= r3_c;
        r4_pfl <= n4_pfl;
        r4_pfh <= n4_pfh;
        r4_prl <= n4_prl;
        r4_prh <= n4_prh;
        for (int i = 0; i < 4; i++) begin
            r4_inr[i] <= r3_inr[i];
        end
    end

    // Stage 5: add the partial products and scale down to drive torque.
    always_comb begin
        sum_f  = 86'(r4_pfl) + (86'(r4_pfh) <<< 18);
        sum_r  = 86'(r4_prl) + (86'(r4_prh) <<< 18);
        n5_drf = $signed(sum_f[85:33]);
        n5_drr = $signed(sum_r[85:33]);
    end

    always_ff @(posedge i_clk) begin
        r5_c   <= r4_c;
        r5_drf <= n5_drf;
        r5_drr <= n5_drr;
        for (int i = 0; i < 4; i++) begin
            r5_inr[i] <= r4_inr[i];
        end
    end

    // Stage 6: net torque and acceleration error as sign and magnitude.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            numw[i] = 54'(i < 2 ? r5_drf : r5_drr)
                    - $signed({{22{r5_c.tt[i][31]}}, r5_c.tt[i]});
            magw[i] = numw[i][53] ? 54'(-numw[i]) : 54'(numw[i]);
            n6_job.mag_w[i]  = magw[i][WheelMagW-1:0];
            n6_job.den_w[i]  = r5_inr[i];
            n6_job.neg_w[i]  = numw[i][53];
            n6_job.stop_w[i] = r5_c.stop[i];
        end
        diff_a = $signed({r5_c.tgt[31], r5_c.tgt}) - $signed({r5_c.acc[31], r5_c.acc});
        abs_a  = diff_a[32] ? 33'(-diff_a) : 33'(diff_a);
        n6_job.mag_a = {abs_a, 16'd0};
        n6_job.neg_a = diff_a[32];
        if (i_cfg.accel_time_constant == '0) begin
            n6_job.den_a = AccelDenW'(1);
        end else begin
            n6_job.den_a = i_cfg.accel_time_constant;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_job <= n6_job;
    end

    assign o_valid = r_v[FrontStages-1];
    assign o_job   = r6_job;

endmodule

`default_nettype wire

// File: src/dwd_queue.sv
// Short item queue between the front and the back of the drivetrain wheel
// derivatives unit. Depends on dwd_pkg.
`default_nettype none

module dwd_queue #(
    parameter int Depth = 2
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  dwd_pkg::t_job  i_job,
    output logic           o_valid,
    output dwd_pkg::t_job  o_job,
    output logic           o_full
);
    import dwd_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            pop;

    // The back has no stall, so the head leaves whenever there is one.
    assign pop     = (r_cnt != '0);
    assign o_valid = pop;
    assign o_job   = r_mem[r_rd];
    assign o_full  = (r_cnt == CntW'(Depth));

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Item storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// File: src/dwd_div.sv
// Pipelined saturating Q.16 divider, one quotient bit per stage, with the
// stopped-wheel clamp at its output. Depends on dwd_pkg.
`default_nettype none

module dwd_div #(
    parameter int MagW = 53,
    parameter int DenW = 43
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire  [MagW-1:0] i_mag,
    input  wire  [DenW-1:0] i_den,
    input  wire             i_neg,
    input  wire             i_stop,
    output logic            o_valid,
    output logic [31:0]     o_res
);
    import dwd_pkg::*;

    localparam int CmpW = (MagW > DenW + 16) ? MagW : DenW + 16;

    logic [DivStages:0] r_v;
    logic [DenW-1:0]    r_rem  [DivStages+1];
    logic [DenW-1:0]    r_den  [DivStages+1];
    logic [31:0]        r_low  [DivStages+1];
    logic [31:0]        r_q    [DivStages+1];
    logic               r_sat  [DivStages+1];
    logic               r_neg  [DivStages+1];
    logic               r_stop [DivStages+1];
    logic [DenW:0]      t      [DivStages];
    logic               ge     [DivStages];
    logic [DenW:0]      n_rem  [DivStages];

    logic [CmpW-1:0]    magx, denx;
    logic               sat0;
    logic [32:0]        res33;
    logic [31:0]        n_res, r_res;
    logic               r_ov;

    // Quotients of 2^16 or more saturate; otherwise the high part of the
    // dividend is already below the divisor.
    assign magx = CmpW'(i_mag);
    assign denx = CmpW'({i_den, 16'd0});
    assign sat0 = (magx >= denx);

    // One restoring step per stage.
    always_comb begin
        for (int g = 0; g < DivStages; g++) begin
            t[g]     = {r_rem[g], r_low[g][31]};
            ge[g]    = (t[g] >= {1'b0, r_den[g]});
            n_rem[g] = ge[g] ? t[g] - {1'b0, r_den[g]} : t[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_v  <= {r_v[DivStages-1:0], i_valid};
            r_ov <= r_v[DivStages];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= sat0 ? '0 : DenW'(magx >> 16);
        r_den[0]  <= i_den;
        r_low[0]  <= {i_mag[15:0], 16'd0};
        r_q[0]    <= '0;
        r_sat[0]  <= sat0;
        r_neg[0]  <= i_neg;
        r_stop[0] <= i_stop;
        for (int g = 0; g < DivStages; g++) begin
            r_rem[g+1]  <= n_rem[g][DenW-1:0];
            r_den[g+1]  <= r_den[g];
            r_low[g+1]  <= {r_low[g][30:0], 1'b0};
            r_q[g+1]    <= {r_q[g][30:0], ge[g]};
            r_sat[g+1]  <= r_sat[g];
            r_neg[g+1]  <= r_neg[g];
            r_stop[g+1] <= r_stop[g];
        end
        r_res <= n_res;
    end

    // Sign, saturation to 32 bits and the stopped-wheel clamp.
    always_comb begin
        res33 = r_sat[DivStages] ? 33'h1_0000_0000 : {1'b0, r_q[DivStages]};
        if (r_neg[DivStages]) begin
            if (res33 >= 33'h0_8000_0000) begin
                n_res = 32'h8000_0000;
            end else begin
                n_res = -r_q[DivStages];
            end
        end else if (res33 > 33'h0_7FFF_FFFF) begin
            n_res = 32'h7FFF_FFFF;
        end else begin
            n_res = r_q[DivStages];
        end
        if (r_stop[DivStages] && n_res[31]) begin
            n_res = '0;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: src/dwd_back.sv
// Back part of the drivetrain wheel derivatives unit: five parallel
// pipelined dividers. Depends on dwd_pkg and dwd_div.
`default_nettype none

module dwd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  dwd_pkg::t_job    i_job,
    output logic             o_valid,
    output logic [3:0][31:0] o_wheel,
    output logic [31:0]      o_rate
);
    import dwd_pkg::*;

    logic [3:0] wheel_v;
    logic       rate_v;

    // One divider per wheel.
    for (genvar i = 0; i < 4; i++) begin : g_wheel
        dwd_div #(
            .MagW(WheelMagW),
            .DenW(WheelDenW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (i_valid),
            .i_mag   (i_job.mag_w[i]),
            .i_den   (i_job.den_w[i]),
            .i_neg   (i_job.neg_w[i]),
            .i_stop  (i_job.stop_w[i]),
            .o_valid (wheel_v[i]),
            .o_res   (o_wheel[i])
        );
    end

    // Acceleration lag divider; no clamp applies here.
    dwd_div #(
        .MagW(AccelMagW),
        .DenW(AccelDenW)
    ) u_rate_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mag   (i_job.mag_a),
        .i_den   (i_job.den_a),
        .i_neg   (i_job.neg_a),
        .i_stop  (1'b0),
        .o_valid (rate_v),
        .o_res   (o_rate)
    );

    // All dividers run in lockstep.
    assign o_valid = rate_v & (&wheel_v);

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for drivetrain_wheel_derivatives_unit: it drives
// directed and random items through several register settings and checks each
// result against a bit-exact predictor. Depends on dwd_pkg and the unit's RTL.
`timescale 1ns / 100ps

module testbench;
    import dwd_pkg::*;

    // One input item of the unit.
    typedef struct {
        logic [31:0] accel_state;
        logic [31:0] speed [4];
        logic [47:0] ext_force;
        logic [31:0] torque [4];
        logic [31:0] accel_target;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic [31:0] i_accel_state;
    logic [31:0] i_speed_fl, i_speed_fr, i_speed_rl, i_speed_rr;
    logic [47:0] i_external_force;
    logic [31:0] i_torque_fl, i_torque_fr, i_torque_rl, i_torque_rr;
    logic [31:0] i_accel_target;
    logic        o_valid;
    logic [31:0] o_wa_fl, o_wa_fr, o_wa_rl, o_wa_rr, o_accel_rate;

    drivetrain_wheel_derivatives_unit dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .start                    (start),
        .busy                     (busy),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_idx                (i_cfg_idx),
        .i_cfg_data               (i_cfg_data),
        .i_accel_state            (i_accel_state),
        .i_speed_front_left       (i_speed_fl),
        .i_speed_front_right      (i_speed_fr),
        .i_speed_rear_left        (i_speed_rl),
        .i_speed_rear_right       (i_speed_rr),
        .i_external_force         (i_external_force),
        .i_tire_torque_front_left (i_torque_fl),
        .i_tire_torque_front_right(i_torque_fr),
        .i_tire_torque_rear_left  (i_torque_rl),
        .i_tire_torque_rear_right (i_torque_rr),
        .i_accel_target           (i_accel_target),
        .o_valid                  (o_valid),
        .o_wheel_accel_front_left (o_wa_fl),
        .o_wheel_accel_front_right(o_wa_fr),
        .o_wheel_accel_rear_left  (o_wa_rl),
        .o_wheel_accel_rear_right (o_wa_rr),
        .o_accel_rate             (o_accel_rate)
    );

    // Mirror of the configuration registers and their widths.
    logic [31:0] reg_mirror [8];
    int          reg_width  [8] = '{32, 17, 17, 18, 18, 25, 25, 25};

    t_item             pending_items [$];
    logic [4:0][31:0]  expected_derivs [$];
    t_item             cur_item;
    int                idle_left;
    bit                quiet;
    int                error_count;
    int                items_sent;
    int                results_seen;
    int                watchdog;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Division as the unit does it: Q.16 quotient, truncated toward zero,
    // saturated to 32 bits; a zero divisor counts as one LSB.
    function automatic logic [31:0] q16_divide(longint num, longint unsigned den);
        longint unsigned mag, q, r, res;
        bit neg;
        neg = (num < 0);
        mag = neg ? longint'(-num) : longint'(num);
        if (den == 0) den = 1;
        q = mag / den;
        r = mag % den;
        if (q >= 65536) res = 64'h1_0000_0000;
        else res = (q << 16) + ((r << 16) / den);
        if (neg) begin
            if (res >= 64'h8000_0000) return 32'h8000_0000;
            res = -res;
            return res[31:0];
        end
        if (res > 64'h7FFF_FFFF) res = 64'h7FFF_FFFF;
        return res[31:0];
    endfunction

    // floor(force * share / 2^33), split so that nothing overflows 64 bits.
    function automatic longint axle_torque(longint force_q16, longint unsigned share);
        longint hi, a, b;
        longint unsigned lo;
        hi = force_q16 >>> 24;
        lo = force_q16 & 64'hFF_FFFF;
        a = hi * longint'(share);
        b = longint'((lo * share) >> 24);
        return (a + b) >>> 9;
    endfunction

    // Expected wheel accelerations and acceleration rate for one item.
    function automatic logic [4:0][31:0] predict_derivs(t_item it);
        logic [4:0][31:0] r;
        longint accel, ext, tgt, force_q16, w, tt, d, drive_f, drive_r;
        longint unsigned bias, inertia, lowspd;
        accel = $signed(it.accel_state);
        ext   = $signed(it.ext_force);
        tgt   = $signed(it.accel_target);
        force_q16 = ((accel * longint'({32'd0, reg_mirror[CFG_VEHICLE_MASS]})) >>> 16) - ext;
        bias = (force_q16 > 0) ? reg_mirror[CFG_ACCEL_BIAS_FRONT]
                               : reg_mirror[CFG_BRAKE_BIAS_FRONT];
        if (bias > 65536) bias = 65536;
        drive_f = axle_torque(force_q16, bias * reg_mirror[CFG_TIRE_RADIUS_FRONT]);
        drive_r = axle_torque(force_q16, (65536 - bias) * reg_mirror[CFG_TIRE_RADIUS_REAR]);
        for (int i = 0; i < 4; i++) begin
            w  = $signed(it.speed[i]);
            tt = $signed(it.torque[i]);
            d  = 1310720 - w;
            lowspd = (d <= 0) ? 0 : ((3 * longint'(reg_mirror[CFG_INERTIA_REAR]) * d) >> 18);
            inertia = ((i < 2) ? reg_mirror[CFG_INERTIA_FRONT]
                               : reg_mirror[CFG_INERTIA_REAR]) + lowspd;
            r[i] = q16_divide(((i < 2) ? drive_f : drive_r) - tt, inertia);
            // A stopped wheel never spins backward.
            if (w <= 0 && r[i][31]) r[i] = 32'd0;
        end
        r[4] = q16_divide((tgt - accel) * 65536, reg_mirror[CFG_ACCEL_TIME_CONSTANT]);
        return r;
    endfunction

    // Random 32-bit value: mostly modest magnitudes, sometimes extremes or full range.
    function automatic logic [31:0] rand_q16(int span_bits);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, (1 << span_bits) - 1)) - (1 << (span_bits - 1));
        endcase
    endfunction

    // Wheel speed: clustered around standstill and the low-speed knee.
    function automatic logic [31:0] rand_speed();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1310720 + $urandom_range(0, 4) - 2;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h40_0000)) - 32'sh10_0000;
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.accel_state = rand_q16(22);
        for (int i = 0; i < 4; i++) begin
            it.speed[i]  = rand_speed();
            it.torque[i] = rand_q16(26);
        end
        case ($urandom_range(0, 5))
            0: it.ext_force = 48'({$urandom, $urandom});
            1: it.ext_force = 48'h7FFF_FFFF_FFFF;
            default: it.ext_force = {{16{1'b0}}, rand_q16(30)};
        endcase
        if (it.ext_force[31] && it.ext_force[47:32] == 16'd0 && $urandom_range(0, 1))
            it.ext_force[47:32] = 16'hFFFF;
        it.accel_target = rand_q16(22);
        return it;
    endfunction

    function automatic t_item fill_item(logic [31:0] a, logic [31:0] w, logic [47:0] f,
                                        logic [31:0] t, logic [31:0] g);
        t_item it;
        it.accel_state = a;
        for (int i = 0; i < 4; i++) begin
            it.speed[i]  = w;
            it.torque[i] = t;
        end
        it.ext_force = f;
        it.accel_target = g;
        return it;
    endfunction

    // Driver: takes items from the pending queue, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                expected_derivs.push_back(predict_derivs(cur_item));
                items_sent++;
            end
            if (start && busy) begin
                // Hold the item until it is taken.
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    idle_left = $urandom_range(0, 3);
                    start <= 1'b0;
                end else begin
                    cur_item = pending_items.pop_front();
                    i_accel_state    <= cur_item.accel_state;
                    i_speed_fl       <= cur_item.speed[0];
                    i_speed_fr       <= cur_item.speed[1];
                    i_speed_rl       <= cur_item.speed[2];
                    i_speed_rr       <= cur_item.speed[3];
                    i_external_force <= cur_item.ext_force;
                    i_torque_fl      <= cur_item.torque[0];
                    i_torque_fr      <= cur_item.torque[1];
                    i_torque_rl      <= cur_item.torque[2];
                    i_torque_rr      <= cur_item.torque[3];
                    i_accel_target   <= cur_item.accel_target;
                    start <= 1'b1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge i_clk) begin
        logic [4:0][31:0] got, want;
        if (i_rst_n && o_valid) begin
            got = {o_accel_rate, o_wa_rr, o_wa_rl, o_wa_fr, o_wa_fl};
            results_seen++;
            if (expected_derivs.size() == 0) begin
                error_count++;
                $display("%0t: result with no item outstanding", $realtime);
            end else begin
                want = expected_derivs.pop_front();
                for (int i = 0; i < 5; i++) begin
                    if (got[i] !== want[i]) begin
                        error_count++;
                        if (error_count <= 40)
                            $display("%0t: field %0d expected %h actual %h",
                                     $realtime, i, want[i], got[i]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no item and no result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) watchdog = 0;
        else watchdog++;
        if (watchdog >= 4000) begin
            $display("Timeout after %0d quiet cycles", watchdog);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Writes a list of register values, one per cycle, then releases the port.
    task automatic write_regs(logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            reg_mirror[i] = 32'(vals[i] & ((64'd1 << reg_width[i]) - 1));
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every item is taken and every result is in, plus the latency.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || start || expected_derivs.size() > 0);
        repeat (50) @(posedge i_clk);
    endtask

    // Stimulus and phase control.
    initial begin
        logic [31:0] vals [8];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_accel_state = '0;
        i_speed_fl = '0; i_speed_fr = '0; i_speed_rl = '0; i_speed_rr = '0;
        i_external_force = '0;
        i_torque_fl = '0; i_torque_fr = '0; i_torque_rl = '0; i_torque_rr = '0;
        i_accel_target = '0;
        quiet = 0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        watchdog = 0;
        reg_mirror = '{RstVehicleMass, RstAccelBiasFront, RstBrakeBiasFront,
                       RstTireRadiusFront, RstTireRadiusRear, RstInertiaFront,
                       RstInertiaRear, RstAccelTimeConst};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset settings: extremes, sign of force,
        // stopped wheels and the low-speed knee.
        pending_items.push_back(fill_item(32'd0, 32'd0, 48'd0, 32'd0, 32'd0));
        pending_items.push_back(fill_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_items.push_back(fill_item(32'h8000_0000, 32'h8000_0000, 48'h8000_0000_0000,
                                          32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(fill_item(32'h7FFF_FFFF, 32'd0, 48'h8000_0000_0000,
                                          32'h8000_0000, 32'h8000_0000));
        pending_items.push_back(fill_item(32'h8000_0000, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_items.push_back(fill_item(32'h0001_0000, 32'd0, 48'd0, 32'h0010_0000, 32'd0));
        pending_items.push_back(fill_item(32'h0001_0000, 32'd1, 48'd0, 32'h0010_0000, 32'd0));
        pending_items.push_back(fill_item(32'hFFFF_0000, 32'd1310720, 48'd0, 32'd0, 32'd0));
        pending_items.push_back(fill_item(32'hFFFF_0000, 32'd1310719, 48'd0, 32'd0, 32'd0));
        pending_items.push_back(fill_item(32'hFFFF_0000, 32'd1310721, 48'd0, 32'd0, 32'd0));
        pending_items.push_back(fill_item(32'd0, 32'h0005_0000, 48'd1, 32'd0, 32'd1));
        pending_items.push_back(fill_item(32'd0, 32'h0005_0000, 48'hFFFF_FFFF_FFFF,
                                          32'd0, 32'hFFFF_FFFF));
        pending_items.push_back(fill_item(32'h0003_0000, 32'h8000_0001, 48'h0000_5000_0000,
                                          32'hFFF0_0000, 32'hFFFD_0000));
        pending_items.push_back(fill_item(32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555,
                                          32'hAAAA_AAAA, 32'h5555_5555));
        pending_items.push_back(fill_item(32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA,
                                          32'h5555_5555, 32'hAAAA_AAAA));
        for (int i = 0; i < 150; i++) pending_items.push_back(rand_item());
        drain();

        // Register settings: extremes high, extremes low with zero divisors, one-LSB
        // inertias, then random ones. Each phase runs a batch of random items.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: vals = '{32'hFFFF_FFFF, 32'h1_FFFF, 32'h1_FFFF, 32'h3_FFFF, 32'h3_FFFF,
                            32'h1FF_FFFF, 32'h1FF_FFFF, 32'h1FF_FFFF};
                1: vals = '{32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
                2: vals = '{32'h0001_0000, 32'd65536, 32'd65536, 32'h2_0000, 32'h2_0000,
                            32'd1, 32'd1, 32'd66};
                default: begin
                    vals[0] = $urandom_range(32'h0001_0000, 32'h1000_0000);
                    vals[1] = $urandom_range(0, 32'h1_FFFF);
                    vals[2] = $urandom_range(0, 32'h1_0000);
                    vals[3] = $urandom_range(0, 32'h2_0000);
                    vals[4] = $urandom;
                    vals[5] = $urandom_range(1, 32'h100_0000);
                    vals[6] = $urandom;
                    vals[7] = $urandom_range(66, 32'h100_0000);
                end
            endcase
            write_regs(vals);
            if (ph == 6) quiet = 1;
            for (int i = 0; i < 160; i++) pending_items.push_back(rand_item());
            drain();
        end

        $display("Covered %0d items and %0d results over eight register settings,",
                 items_sent, results_seen);
        $display("including saturating extremes, zero divisors and stopped wheels.");
        if (error_count == 0 && expected_derivs.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
